### hdl/stel_pkg.sv
// Shared types and codes for the sorted time event table.
// Holds action and status codes, the sequencer state type and the result beat.
// No dependencies.
`default_nettype none

package stel_pkg;

	// Field widths fixed by the interface.
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int TAG_W    = 16;
	localparam int SLOT_W   = 5;
	localparam int COUNT_W  = 6;
	localparam int KEY_W    = HOUR_W + MINUTE_W;
	localparam int ENTRY_W  = KEY_W + TAG_W;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_READ   = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_NOTOCC = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_RD_CAP,
		ST_DEL_CAP,
		ST_DEL_SHIFT,
		ST_DONE
	} seq_state_t;

	// One result beat as handed from the sequencer to the output register.
	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [TAG_W-1:0]    tag;
		logic [COUNT_W-1:0]  count;
	} result_t;

endpackage

`default_nettype wire

### hdl/sorted_time_event_table.sv
// Top level of the sorted time event table: sequencer, entry memory, result register.
// Depends on stel_pkg, stel_store and stel_ctrl.
//
//  channel   direction  handshake            beat
//  request   in         req_valid/req_stall  action, event_hour, event_minute, event_tag, position
//  response  out        rsp_valid/rsp_stall  status, slot, out_hour, out_minute, out_tag, entry_count
//
// One request beat at a time. A read captures one entry; an insert moves each entry with a later
// time up one place, and a delete moves each entry above the position down one; an insert into an
// empty table, a rejected request and the unused action code go straight to the result.
// The walk is set by the single memory read and write port, one entry per cycle.
// Reset empties the table at once; entries are never cleared, only the count.
// A stalled response holds; the next request is taken while it waits.
`default_nettype none

module sorted_time_event_table #(
	parameter int CAPACITY = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [1:0]                    action,
	input  wire logic [stel_pkg::HOUR_W-1:0]   event_hour,
	input  wire logic [stel_pkg::MINUTE_W-1:0] event_minute,
	input  wire logic [stel_pkg::TAG_W-1:0]    event_tag,
	input  wire logic [stel_pkg::SLOT_W-1:0]   position,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic      [1:0]                    status,
	output logic      [stel_pkg::SLOT_W-1:0]   slot,
	output logic      [stel_pkg::HOUR_W-1:0]   out_hour,
	output logic      [stel_pkg::MINUTE_W-1:0] out_minute,
	output logic      [stel_pkg::TAG_W-1:0]    out_tag,
	output logic      [stel_pkg::COUNT_W-1:0]  entry_count
);
	import stel_pkg::*;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	logic               busy, done, accept, res_free;
	result_t            res;
	result_t            rsp_q;
	logic               rsp_valid_q;
	logic               wr_en, rd_en;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	logic [ENTRY_W-1:0] wr_data, rd_data;

	assign req_stall = busy;
	assign accept    = req_valid && !busy;
	assign res_free  = !rsp_valid_q || !rsp_stall;

	stel_ctrl #(
		.CAPACITY (CAPACITY),
		.ADDR_W   (ADDR_W),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (action),
		.event_hour   (event_hour),
		.event_minute (event_minute),
		.event_tag    (event_tag),
		.position     (position),
		.res_free     (res_free),
		.busy         (busy),
		.done         (done),
		.res          (res),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	stel_store #(
		.DEPTH  (CAPACITY),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_free) begin
			rsp_valid_q <= done;
		end
	end

	// Response payload, loaded only when the register is free.
	always_ff @(posedge clk) begin
		if (done && res_free) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_q.status;
	assign slot        = rsp_q.slot;
	assign out_hour    = rsp_q.hour;
	assign out_minute  = rsp_q.minute;
	assign out_tag     = rsp_q.tag;
	assign entry_count = rsp_q.count;

endmodule

`default_nettype wire

### hdl/stel_store.sv
// Entry memory for the sorted time event table: one write port, one read port.
// Read data is registered. Depends on stel_pkg.
`default_nettype none

module stel_store #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [ADDR_W-1:0]            wr_addr,
	input  wire logic [stel_pkg::ENTRY_W-1:0] wr_data,
	input  wire logic                         rd_en,
	input  wire logic [ADDR_W-1:0]            rd_addr,
	output logic      [stel_pkg::ENTRY_W-1:0] rd_data
);
	import stel_pkg::*;

	logic [ENTRY_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/stel_ctrl.sv
// Sequencer and shared key comparator of the sorted time event table.
// Walks the entry memory one position per cycle to insert or delete, and reads one entry.
// Depends on stel_pkg; drives the ports of stel_store.
`default_nettype none

module stel_ctrl #(
	parameter int CAPACITY = 32,
	parameter int ADDR_W   = 5,
	parameter int CNT_W    = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [1:0]                    action,
	input  wire logic [stel_pkg::HOUR_W-1:0]   event_hour,
	input  wire logic [stel_pkg::MINUTE_W-1:0] event_minute,
	input  wire logic [stel_pkg::TAG_W-1:0]    event_tag,
	input  wire logic [stel_pkg::SLOT_W-1:0]   position,
	input  wire logic                          res_free,
	output logic                               busy,
	output logic                               done,
	output stel_pkg::result_t                  res,
	output logic                               wr_en,
	output logic      [ADDR_W-1:0]             wr_addr,
	output logic      [stel_pkg::ENTRY_W-1:0]  wr_data,
	output logic                               rd_en,
	output logic      [ADDR_W-1:0]             rd_addr,
	input  wire logic [stel_pkg::ENTRY_W-1:0]  rd_data
);
	import stel_pkg::*;

	// Index arithmetic runs in a width that holds the count plus two and the output fields.
	localparam int IDX_W = CNT_W + 1;
	localparam int CW    = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

	seq_state_t         state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [CW-1:0]      idx_q;
	logic [ENTRY_W-1:0] new_q;
	logic [ENTRY_W-1:0] data_q;
	status_t            status_q;
	logic [SLOT_W-1:0]  slot_q;

	logic [CW-1:0]      cnt_w, pos_w, cap_w, idx_p1, idx_p2, idx_m1;
	logic [ENTRY_W-1:0] in_entry;
	logic               key_gt, is_full, is_empty, pos_bad, del_last, shift_last;

	// Widened views and the shared comparator.
	assign cnt_w      = CW'(count_q);
	assign pos_w      = CW'(position);
	assign cap_w      = CW'(CAPACITY);
	assign idx_p1     = idx_q + CW'(1);
	assign idx_p2     = idx_q + CW'(2);
	assign idx_m1     = idx_q - CW'(1);
	assign in_entry   = {event_hour, event_minute, event_tag};
	assign key_gt     = rd_data[ENTRY_W-1:TAG_W] > new_q[ENTRY_W-1:TAG_W];
	assign is_full    = (cnt_w == cap_w);
	assign is_empty   = (cnt_w == '0);
	assign pos_bad    = (pos_w >= cnt_w);
	assign del_last   = (idx_p1 >= cnt_w);
	assign shift_last = (idx_p2 >= cnt_w);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action_t'(action))
						ACT_INSERT: state_d = (is_full || is_empty) ? ST_DONE : ST_INS_CMP;
						ACT_DELETE: state_d = pos_bad ? ST_DONE : ST_DEL_CAP;
						ACT_READ:   state_d = pos_bad ? ST_DONE : ST_RD_CAP;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_INS_CMP: begin
				if (!key_gt) begin
					state_d = ST_DONE;
				end else if (idx_q == '0) begin
					state_d = ST_INS_PUT;
				end
			end
			ST_INS_PUT:   state_d = ST_DONE;
			ST_RD_CAP:    state_d = ST_DONE;
			ST_DEL_CAP:   state_d = del_last ? ST_DONE : ST_DEL_SHIFT;
			ST_DEL_SHIFT: state_d = shift_last ? ST_DONE : ST_DEL_SHIFT;
			ST_DONE:      state_d = res_free ? ST_IDLE : ST_DONE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Memory port controls.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = new_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action_t'(action))
						ACT_INSERT: begin
							if (is_empty) begin
								wr_en   = 1'b1;
								wr_data = in_entry;
							end else if (!is_full) begin
								rd_en   = 1'b1;
								rd_addr = ADDR_W'(cnt_w - CW'(1));
							end
						end
						ACT_DELETE, ACT_READ: begin
							rd_en   = !pos_bad;
							rd_addr = ADDR_W'(pos_w);
						end
						default: begin
						end
					endcase
				end
			end
			ST_INS_CMP: begin
				// Later entries move up one place; the new one lands above the first that is not later.
				wr_en   = 1'b1;
				wr_addr = ADDR_W'(idx_p1);
				wr_data = key_gt ? rd_data : new_q;
				if (key_gt && idx_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(idx_m1);
				end
			end
			ST_INS_PUT: begin
				wr_en = 1'b1;
			end
			ST_DEL_CAP: begin
				rd_en   = !del_last;
				rd_addr = ADDR_W'(idx_p1);
			end
			ST_DEL_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = ADDR_W'(idx_q);
				wr_data = rd_data;
				rd_en   = !shift_last;
				rd_addr = ADDR_W'(idx_p2);
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept && action_t'(action) == ACT_INSERT && is_empty) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_INS_CMP: begin
					if (!key_gt) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_INS_PUT: count_q <= count_q + CNT_W'(1);
				ST_DEL_CAP: begin
					if (del_last) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				ST_DEL_SHIFT: begin
					if (shift_last) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the current action.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					new_q    <= in_entry;
					status_q <= STAT_DONE;
					slot_q   <= '0;
					data_q   <= '0;
					case (action_t'(action))
						ACT_INSERT: begin
							idx_q <= cnt_w - CW'(1);
							if (is_full) begin
								status_q <= STAT_FULL;
							end else if (is_empty) begin
								data_q <= in_entry;
							end
						end
						ACT_DELETE, ACT_READ: begin
							idx_q    <= pos_w;
							slot_q   <= position;
							status_q <= pos_bad ? STAT_NOTOCC : STAT_DONE;
						end
						default: idx_q <= '0;
					endcase
				end
			end
			ST_INS_CMP: begin
				if (key_gt) begin
					idx_q <= idx_m1;
				end else begin
					slot_q <= idx_p1[SLOT_W-1:0];
					data_q <= new_q;
				end
			end
			ST_INS_PUT: begin
				slot_q <= '0;
				data_q <= new_q;
			end
			ST_RD_CAP:    data_q <= rd_data;
			ST_DEL_CAP:   data_q <= rd_data;
			ST_DEL_SHIFT: idx_q  <= idx_p1;
			default: begin
			end
		endcase
	end

	// Result beat and handshake status.
	assign busy       = (state_q != ST_IDLE);
	assign done       = (state_q == ST_DONE);
	assign res.status = status_q;
	assign res.slot   = slot_q;
	assign res.hour   = data_q[ENTRY_W-1:KEY_W+MINUTE_W-HOUR_W+TAG_W-MINUTE_W];
	assign res.minute = data_q[TAG_W+MINUTE_W-1:TAG_W];
	assign res.tag    = data_q[TAG_W-1:0];
	assign res.count  = cnt_w[COUNT_W-1:0];

endmodule

`default_nettype wire

### hdl/stel_chk.sv
// Port-level checks for the sorted time event table, bound to the top level.
// Depends on stel_pkg and sorted_time_event_table.
`default_nettype none

module stel_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_stall,
	input wire logic        rsp_valid,
	input wire logic        rsp_stall,
	input wire logic [1:0]  status,
	input wire logic [4:0]  slot,
	input wire logic [4:0]  out_hour,
	input wire logic [5:0]  out_minute,
	input wire logic [15:0] out_tag,
	input wire logic [5:0]  entry_count
);
	import stel_pkg::*;

	// A stalled response beat stays valid and holds its status, slot, tag and count.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(slot)
			&& $stable(out_tag) && $stable(entry_count))
		else $error("stalled response beat changed");

	// The table takes one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in work");

	// A rejected insert carries no position and no entry.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_FULL |->
			slot == '0 && out_hour == '0 && out_minute == '0 && out_tag == '0)
		else $error("table full response carries data");

	// A position outside the table yields no entry.
	a_notocc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_NOTOCC |->
			out_hour == '0 && out_minute == '0 && out_tag == '0)
		else $error("unoccupied position response carries data");

endmodule

bind sorted_time_event_table stel_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.status      (status),
	.slot        (slot),
	.out_hour    (out_hour),
	.out_minute  (out_minute),
	.out_tag     (out_tag),
	.entry_count (entry_count)
);

`default_nettype wire
